// ===== src/low_rank_cholesky_factor_engine_defines.svh =====
// assertion macros for the low-rank cholesky factor engine checker
// no dependencies
`ifndef LOW_RANK_CHOLESKY_FACTOR_ENGINE_DEFINES_SVH
`define LOW_RANK_CHOLESKY_FACTOR_ENGINE_DEFINES_SVH
`define LRC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("lrc check failed");
`define LRC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("lrc check failed");
`endif

// ===== src/lrcf_pkg.sv =====
// shared constants and types for the low-rank cholesky factor engine
// no dependencies
`timescale 1ns / 1ps
package lrcf_pkg;
	localparam int MaxSlots = 16;
	localparam int MaxDim = 32;
	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_MUL = 2'd1;
	localparam logic [1:0] OP_INV = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [2:0] REG_SLOTS = 3'd0;
	localparam logic [2:0] REG_DIM = 3'd1;
	localparam logic [2:0] REG_GAP = 3'd2;
	localparam logic [2:0] REG_DECAY = 3'd3;
	localparam logic [2:0] REG_INVDECAY = 3'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] element_index;
		logic signed [31:0] element_value;
		logic signed [31:0] coeff_b;
		logic signed [31:0] coeff_d;
		logic [31:0] iteration;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [4:0] result_index;
		logic last_of_run;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// round half up of a q8.24 product
	function automatic logic signed [40:0] rnd24(input logic signed [64:0] p);
		logic signed [64:0] t;
		t = p + 65'sd8388608;
		return t[64:24];
	endfunction
endpackage

// ===== src/lrcf_if.sv =====
// valid/ready channel interfaces for the engine
// depends on lrcf_pkg
`timescale 1ns / 1ps
interface lrcf_in_if;
	logic valid;
	logic ready;
	lrcf_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lrcf_out_if;
	logic valid;
	logic ready;
	lrcf_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/low_rank_cholesky_factor_engine.sv =====
// low-rank cholesky factor engine: slot store, eviction and factor products
// depends on lrcf_pkg and lrcf_if
//
// usage: items arrive on in_ch (valid/ready). store items write one element of a
// direction vector; the element at index 0 picks a slot (eviction walks the
// order one pair per cycle). multiply items load z; the last element starts a
// product. for each of n slots one mac runs over the vector for the dot (a read
// state and a multiply state per element), then a coefficient state, then three
// update states per element. a product keeps in_ch.ready low while it runs and
// while its dim results go out on out_ch, one per cycle the receiver takes them.
// a store element at index 0 passes through the slot and write states, after the
// evict and shift states when a slot is evicted; any other store element through
// the write state only. ignored items and other multiply elements leave the block
// idle. a stalled receiver holds the result register and the block waits.
// reset: order is identity, no slots stored, registers at their defaults.
// no clearing pass: never-written entries read as undefined.
`timescale 1ns / 1ps
module low_rank_cholesky_factor_engine #(
	parameter int MAX_SLOTS = lrcf_pkg::MaxSlots,
	parameter int MAX_DIM = lrcf_pkg::MaxDim
) (
	input logic clk,
	input logic arst_n,
	lrcf_in_if.sink in_ch,
	lrcf_out_if.source out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [26:0] cfg_data
);
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int AW = (MAX_SLOTS * MAX_DIM > 1) ? $clog2(MAX_SLOTS * MAX_DIM) : 1;
	localparam int DCAP = (MAX_DIM < 32) ? MAX_DIM : 32;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EVICT = 4'd1;
	localparam logic [3:0] ST_SHIFT = 4'd2;
	localparam logic [3:0] ST_WRITE = 4'd3;
	localparam logic [3:0] ST_SLOT = 4'd4;
	localparam logic [3:0] ST_DOTR = 4'd5;
	localparam logic [3:0] ST_DOTM = 4'd6;
	localparam logic [3:0] ST_COEF = 4'd7;
	localparam logic [3:0] ST_UPDR = 4'd8;
	localparam logic [3:0] ST_UPDA = 4'd9;
	localparam logic [3:0] ST_UPDC = 4'd10;
	localparam logic [3:0] ST_EMIT = 4'd11;

	logic [3:0] state_q;
	logic [4:0] slots_q;
	logic [5:0] dim_q;
	logic [15:0] gap_q;
	logic [25:0] decay_q;
	logic [26:0] invdecay_q;

	logic signed [31:0] vmem [MAX_SLOTS*MAX_DIM];
	logic signed [31:0] fcoef [MAX_SLOTS];
	logic signed [31:0] icoef [MAX_SLOTS];
	logic [31:0] stamp [MAX_SLOTS];
	logic signed [31:0] opbuf [MAX_DIM];
	logic signed [31:0] work [MAX_DIM];
	logic [SW-1:0] order_q [MAX_SLOTS];
	logic [CW-1:0] count_q;
	logic [SW-1:0] cur_q;

	lrcf_pkg::in_item_t it_q;
	logic inv_q;
	logic [CW-1:0] t_q;
	logic [DW-1:0] j_q;
	logic [SW-1:0] pos_q;
	logic signed [33:0] best_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] v_q, x_q, coeff_q;
	logic signed [40:0] a_q;
	logic [SW-1:0] k_q;

	logic [CW-1:0] m_eff, n_eff;
	logic [5:0] d_eff;
	always_comb begin
		if (slots_q == 5'd0) m_eff = CW'(1);
		else if (32'(slots_q) > MAX_SLOTS) m_eff = CW'(MAX_SLOTS);
		else m_eff = CW'(slots_q);
		n_eff = (count_q < m_eff) ? count_q : m_eff;
		if (dim_q == 6'd0) d_eff = 6'd1;
		else if (32'(dim_q) > DCAP) d_eff = 6'(DCAP);
		else d_eff = dim_q;
	end

	// single shared multiplier
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] mul_p;
	logic signed [40:0] mul_r;
	always_comb begin
		mul_a = {v_q[31], v_q};
		mul_b = x_q;
		unique case (state_q)
			ST_COEF: begin
				mul_a = inv_q ? {icoef[k_q][31], icoef[k_q]} : {fcoef[k_q][31], fcoef[k_q]};
				mul_b = lrcf_pkg::sat32(acc_q);
			end
			ST_UPDA: begin
				mul_a = inv_q ? 33'($unsigned(invdecay_q)) : 33'($unsigned(decay_q));
				mul_b = x_q;
			end
			ST_UPDC: begin
				mul_a = {coeff_q[31], coeff_q};
				mul_b = v_q;
			end
			default: ;
		endcase
		mul_p = 65'(mul_a) * 65'(mul_b);
		mul_r = lrcf_pkg::rnd24(mul_p);
	end

	logic [DW-1:0] jlast;
	assign jlast = DW'(d_eff - 6'd1);
	logic [DW-1:0] idx_d;
	assign idx_d = DW'(in_ch.data.element_index);
	logic in_ok;
	assign in_ok = (6'(in_ch.data.element_index) < d_eff) &&
		(in_ch.data.operation != lrcf_pkg::OP_NONE);

	assign in_ch.ready = (state_q == ST_IDLE);

	logic signed [33:0] gap_w;
	assign gap_w = 34'($signed({2'b0, stamp[order_q[pos_q + SW'(1)]]})) -
		34'($signed({2'b0, stamp[order_q[pos_q]]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slots_q <= 5'd16;
			dim_q <= 6'd32;
			gap_q <= 16'd32;
			decay_q <= 26'd16535435;
			invdecay_q <= 27'd17022500;
			count_q <= '0;
			cur_q <= '0;
			out_ch.valid <= 1'b0;
			for (int k = 0; k < MAX_SLOTS; k++) order_q[k] <= SW'(k);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lrcf_pkg::REG_SLOTS: slots_q <= cfg_data[4:0];
					lrcf_pkg::REG_DIM: dim_q <= cfg_data[5:0];
					lrcf_pkg::REG_GAP: gap_q <= cfg_data[15:0];
					lrcf_pkg::REG_DECAY: decay_q <= cfg_data[25:0];
					lrcf_pkg::REG_INVDECAY: invdecay_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_ch.valid && in_ok) begin
					it_q <= in_ch.data;
					inv_q <= (in_ch.data.operation == lrcf_pkg::OP_INV);
					if (in_ch.data.operation == lrcf_pkg::OP_STORE) begin
						if (in_ch.data.element_index != 5'd0) state_q <= ST_WRITE;
						else if (count_q < m_eff) begin
							order_q[count_q[SW-1:0]] <= count_q[SW-1:0];
							cur_q <= count_q[SW-1:0];
							count_q <= count_q + CW'(1);
							state_q <= ST_SLOT;
						end else if (m_eff == CW'(1)) begin
							cur_q <= order_q[0];
							state_q <= ST_SLOT;
						end else begin
							pos_q <= '0;
							best_q <= 34'sh1ffffffff;
							k_q <= SW'(1);
							state_q <= ST_EVICT;
						end
					end else begin
						opbuf[idx_d] <= in_ch.data.element_value;
						if (idx_d == jlast) begin
							t_q <= '0;
							state_q <= ST_DOTR;
							j_q <= '0;
							acc_q <= '0;
							for (int k = 0; k < MAX_DIM; k++)
								work[k] <= (k == 32'(idx_d)) ? in_ch.data.element_value
									: opbuf[k];
						end
					end
				end
				ST_EVICT: begin
					// pos_q walks pairs; k_q holds best position
					if (gap_w < best_q) begin
						best_q <= gap_w;
						k_q <= pos_q + SW'(1);
					end
					if (CW'(pos_q) + CW'(2) >= m_eff) begin
						state_q <= ST_SHIFT;
						pos_q <= ((gap_w < best_q ? gap_w : best_q) >= 34'($signed({18'b0, gap_q})))
							? SW'(0) : ((gap_w < best_q) ? pos_q + SW'(1) : k_q);
					end else pos_q <= pos_q + SW'(1);
				end
				ST_SHIFT: begin
					cur_q <= order_q[pos_q];
					for (int k = 0; k < MAX_SLOTS - 1; k++)
						if (k >= 32'(pos_q) && 32'(k) + 1 < 32'(m_eff)) order_q[k] <= order_q[k+1];
					order_q[SW'(m_eff - CW'(1))] <= order_q[pos_q];
					state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					fcoef[cur_q] <= it_q.coeff_b;
					icoef[cur_q] <= it_q.coeff_d;
					stamp[cur_q] <= it_q.iteration;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					vmem[AW'(32'(cur_q) * MAX_DIM + 32'(DW'(it_q.element_index)))] <=
						it_q.element_value;
					state_q <= ST_IDLE;
				end
				ST_DOTR: begin
					if (t_q >= n_eff) begin
						j_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						k_q <= order_q[t_q[SW-1:0]];
						v_q <= vmem[AW'(32'(order_q[t_q[SW-1:0]]) * MAX_DIM + 32'(j_q))];
						x_q <= inv_q ? work[j_q] : opbuf[j_q];
						state_q <= ST_DOTM;
					end
				end
				ST_DOTM: begin
					acc_q <= acc_q + 66'(mul_r);
					if (j_q == jlast) begin
						j_q <= '0;
						state_q <= ST_COEF;
					end else begin
						j_q <= j_q + DW'(1);
						state_q <= ST_DOTR;
					end
				end
				ST_COEF: begin
					coeff_q <= lrcf_pkg::sat32(66'(mul_r));
					state_q <= ST_UPDR;
				end
				ST_UPDR: begin
					v_q <= vmem[AW'(32'(k_q) * MAX_DIM + 32'(j_q))];
					x_q <= work[j_q];
					state_q <= ST_UPDA;
				end
				ST_UPDA: begin
					a_q <= mul_r;
					state_q <= ST_UPDC;
				end
				ST_UPDC: begin
					work[j_q] <= lrcf_pkg::sat32(inv_q ? 66'(a_q) - 66'(mul_r)
						: 66'(a_q) + 66'(mul_r));
					if (j_q == jlast) begin
						j_q <= '0;
						acc_q <= '0;
						t_q <= t_q + CW'(1);
						state_q <= ST_DOTR;
					end else begin
						j_q <= j_q + DW'(1);
						state_q <= ST_UPDR;
					end
				end
				ST_EMIT: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.valid <= 1'b1;
						out_ch.data.result_value <= work[j_q];
						out_ch.data.result_index <= 5'(j_q);
						out_ch.data.last_of_run <= (j_q == jlast);
						if (j_q == jlast) state_q <= ST_IDLE;
						j_q <= j_q + DW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q != ST_EMIT && out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
		end
	end
endmodule

// ===== src/lrcf_checker.sv =====
// port-level assertions for the engine, bound into every engine instance
// depends on the defines header and the engine it binds into
`timescale 1ns / 1ps
`include "low_rank_cholesky_factor_engine_defines.svh"
module lrcf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_value,
	input logic last
);
	`LRC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_value))
	`LRC_ASSERT_IMPL(a_busy, clk, arst_n, out_valid && !last, !in_ready)
	`LRC_ASSERT_NEXT(a_stream, clk, arst_n, out_valid && out_ready && !last, out_valid)
endmodule

bind low_rank_cholesky_factor_engine lrcf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_value(out_ch.data.result_value), .last(out_ch.data.last_of_run)
);

// ===== verif/lrcf_product_checker.sv =====
// checker for the low-rank cholesky factor engine: mirrors register writes and
// input transfers, predicts every product element and compares result transfers
// depends on lrcf_pkg and the channel interfaces in lrcf_if
`timescale 1ns / 1ps
module lrcf_product_checker (
	input logic clk,
	input logic arst_n,
	lrcf_in_if in_ch,
	lrcf_out_if out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [26:0] cfg_data,
	output int fail_count,
	output int pending,
	output int results_seen
);
	int dir_vec[lrcf_pkg::MaxSlots][lrcf_pkg::MaxDim];
	int fwd_coef[lrcf_pkg::MaxSlots];
	int inv_coef[lrcf_pkg::MaxSlots];
	logic [31:0] stamp[lrcf_pkg::MaxSlots];
	logic [3:0] order[lrcf_pkg::MaxSlots];
	int n_stored;
	int z_buf[lrcf_pkg::MaxDim];
	int x_vec[lrcf_pkg::MaxDim];
	int cur_slot;
	logic [4:0] slots_reg;
	logic [5:0] dim_reg;
	logic [15:0] gap_reg;
	logic [25:0] decay_reg;
	logic [26:0] invdecay_reg;
	lrcf_pkg::out_item_t product_q[$];

	function automatic longint round_q24(longint p);
		return (p + 64'sd8388608) >>> 24;
	endfunction

	function automatic int clip32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	function automatic int slot_limit();
		if (slots_reg == 0) return 1;
		return (slots_reg > lrcf_pkg::MaxSlots) ? lrcf_pkg::MaxSlots : int'(slots_reg);
	endfunction

	function automatic int vec_len();
		if (dim_reg == 0) return 1;
		return (dim_reg > lrcf_pkg::MaxDim) ? lrcf_pkg::MaxDim : int'(dim_reg);
	endfunction

	function automatic int choose_slot();
		int m;
		int pos;
		longint best;
		longint gap;
		logic [3:0] moved;
		m = slot_limit();
		if (n_stored < m) begin
			order[n_stored] = n_stored[3:0];
			n_stored++;
			return n_stored - 1;
		end
		if (m == 1) return int'(order[0]);
		pos = 1;
		best = longint'(stamp[order[1]]) - longint'(stamp[order[0]]);
		for (int i = 1; i + 1 < m; i++) begin
			gap = longint'(stamp[order[i + 1]]) - longint'(stamp[order[i]]);
			if (gap < best) begin
				best = gap;
				pos = i + 1;
			end
		end
		if (best >= longint'(gap_reg)) pos = 0;
		moved = order[pos];
		for (int i = pos; i + 1 < m; i++) order[i] = order[i + 1];
		order[m - 1] = moved;
		return int'(moved);
	endfunction

	function automatic void factor_product(bit inv, int len);
		int m;
		int n;
		int k;
		longint dot;
		longint coeff;
		longint scale;
		longint a;
		longint c;
		lrcf_pkg::out_item_t r;
		m = slot_limit();
		n = (n_stored < m) ? n_stored : m;
		x_vec = z_buf;
		scale = inv ? longint'(invdecay_reg) : longint'(decay_reg);
		for (int t = 0; t < n; t++) begin
			k = int'(order[t]);
			dot = 0;
			for (int j = 0; j < len; j++)
				dot += round_q24(longint'(dir_vec[k][j]) * (inv ? x_vec[j] : z_buf[j]));
			dot = clip32(dot);
			coeff = clip32(round_q24(longint'(inv ? inv_coef[k] : fwd_coef[k]) * dot));
			for (int j = 0; j < len; j++) begin
				a = round_q24(scale * x_vec[j]);
				c = round_q24(coeff * dir_vec[k][j]);
				x_vec[j] = clip32(inv ? a - c : a + c);
			end
		end
		for (int j = 0; j < len; j++) begin
			r.result_value = x_vec[j];
			r.result_index = j[4:0];
			r.last_of_run = (j == len - 1);
			product_q = {product_q, r};
		end
	endfunction

	function automatic void take_item(lrcf_pkg::in_item_t it);
		int len;
		len = vec_len();
		if (it.element_index >= len || it.operation == lrcf_pkg::OP_NONE) return;
		if (it.operation == lrcf_pkg::OP_STORE) begin
			if (it.element_index == 0) begin
				cur_slot = choose_slot();
				fwd_coef[cur_slot] = it.coeff_b;
				inv_coef[cur_slot] = it.coeff_d;
				stamp[cur_slot] = it.iteration;
			end
			dir_vec[cur_slot][it.element_index] = it.element_value;
			return;
		end
		z_buf[it.element_index] = it.element_value;
		if (it.element_index == len - 1)
			factor_product(it.operation == lrcf_pkg::OP_INV, len);
	endfunction

	assign pending = product_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lrcf_pkg::MaxSlots; k++) order[k] = k[3:0];
			n_stored = 0;
			cur_slot = 0;
			slots_reg = 5'd16;
			dim_reg = 6'd32;
			gap_reg = 16'd32;
			decay_reg = 26'd16535435;
			invdecay_reg = 27'd17022500;
			product_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lrcf_pkg::REG_SLOTS: slots_reg = cfg_data[4:0];
					lrcf_pkg::REG_DIM: dim_reg = cfg_data[5:0];
					lrcf_pkg::REG_GAP: gap_reg = cfg_data[15:0];
					lrcf_pkg::REG_DECAY: decay_reg = cfg_data[25:0];
					lrcf_pkg::REG_INVDECAY: invdecay_reg = cfg_data[26:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (product_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: value %0d index %0d last %0b",
							out_ch.data.result_value, out_ch.data.result_index,
							out_ch.data.last_of_run);
				end else begin
					if (out_ch.data !== product_q[0]) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
								product_q[0].result_value, product_q[0].result_index,
								product_q[0].last_of_run, out_ch.data.result_value,
								out_ch.data.result_index, out_ch.data.last_of_run);
					end
					void'(product_q.pop_front());
				end
			end
			if (in_ch.valid && in_ch.ready) take_item(in_ch.data);
		end
	end
endmodule

// ===== verif/tb.sv =====
// testbench top for the low-rank cholesky factor engine: directed and random
// store and multiply streams under several register settings with bursty input
// depends on lrcf_pkg, lrcf_if, the engine and lrcf_product_checker
`timescale 1ns / 1ps
module tb;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [26:0] cfg_data;
	int fail_count;
	int pending;
	int results_seen;
	int burst_left;
	int items_sent;
	int settings_used;
	bit squeeze;
	logic [31:0] stamp_now;

	lrcf_in_if in_ch();
	lrcf_out_if out_ch();

	low_rank_cholesky_factor_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lrcf_product_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// receiver: alternating windows of free flow and random stalls, long hold-offs while squeeze is set
	initial begin
		int hold;
		int window;
		bit choppy;
		hold = 0;
		window = 0;
		choppy = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze && hold == 0) hold = 600;
			if (window == 0) begin
				window = $urandom_range(20, 120);
				choppy = ~choppy;
			end
			window--;
			if (hold > 0) begin
				hold--;
				out_ch.ready <= (hold == 0);
			end else if (choppy) begin
				out_ch.ready <= ($urandom_range(0, 2) != 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send(lrcf_pkg::in_item_t it);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [26:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		settings_used++;
	endtask

	task automatic store_vector(int len, logic [31:0] stamp_val, bit extreme);
		lrcf_pkg::in_item_t it;
		for (int j = 0; j < len; j++) begin
			it.operation = lrcf_pkg::OP_STORE;
			it.element_index = j[4:0];
			it.element_value = extreme ? (j[0] ? 32'sh7fffffff : 32'sh80000000) : $urandom;
			it.coeff_b = extreme ? 32'sh7fffffff : $urandom;
			it.coeff_d = extreme ? 32'sh80000000 : $urandom;
			it.iteration = stamp_val;
			send(it);
		end
	endtask

	task automatic multiply_vector(int len, logic [1:0] op, bit mixed);
		lrcf_pkg::in_item_t it;
		for (int j = 0; j < len; j++) begin
			it = '0;
			it.operation = (mixed && j != len - 1) ? 2'($urandom_range(1, 2)) : op;
			it.element_index = j[4:0];
			it.element_value = $urandom;
			if ($urandom_range(0, 5) == 0) it.element_value = j[0] ? 32'sh7fffffff : 32'sh80000000;
			it.coeff_b = $urandom;
			it.coeff_d = $urandom;
			it.iteration = $urandom;
			send(it);
		end
	endtask

	task automatic random_phase(int len, int n_items);
		lrcf_pkg::in_item_t it;
		int r;
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				case ($urandom_range(0, 5))
					0: stamp_now = $urandom;
					1: stamp_now = stamp_now - $urandom_range(1, 50);
					default: stamp_now = stamp_now + $urandom_range(0, 40);
				endcase
				store_vector(len, stamp_now, 1'b0);
			end else if (r < 85) begin
				multiply_vector(len, $urandom_range(0, 1) ? lrcf_pkg::OP_MUL : lrcf_pkg::OP_INV,
					$urandom_range(0, 3) == 0);
			end else begin
				it.operation = lrcf_pkg::OP_NONE;
				it.element_index = 5'($urandom);
				it.element_value = $urandom;
				it.coeff_b = $urandom;
				it.coeff_d = $urandom;
				it.iteration = $urandom;
				if (r < 92 && len < lrcf_pkg::MaxDim) begin
					// index out of range for the current length, for any operation but none
					it.operation = 2'($urandom_range(0, 2));
					it.element_index = 5'($urandom_range(len, lrcf_pkg::MaxDim - 1));
				end else if (r < 96 && len > 1) begin
					// stray store element into the current slot
					it.operation = lrcf_pkg::OP_STORE;
					it.element_index = 5'($urandom_range(1, len - 1));
				end
				send(it);
			end
		end
	endtask

	initial begin
		lrcf_pkg::in_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lrcf_pkg::REG_SLOTS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		squeeze = 1'b0;
		burst_left = 0;
		items_sent = 0;
		settings_used = 0;
		stamp_now = 32'd100;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// full length, single slot, extreme scale factors
		write_reg(lrcf_pkg::REG_SLOTS, 27'd0);
		write_reg(lrcf_pkg::REG_DIM, 27'd63);
		write_reg(lrcf_pkg::REG_GAP, 27'd1);
		write_reg(lrcf_pkg::REG_DECAY, 27'd33554432);
		write_reg(lrcf_pkg::REG_INVDECAY, 27'd67108864);
		store_vector(lrcf_pkg::MaxDim, 32'h0000_0000, 1'b1);
		it = '0;
		it.operation = lrcf_pkg::OP_NONE;
		it.element_index = 5'd31;
		send(it);
		multiply_vector(lrcf_pkg::MaxDim, lrcf_pkg::OP_INV, 1'b1);
		drain();

		// short vectors with eviction across several slots, receiver held off
		write_reg(lrcf_pkg::REG_DIM, 27'd4);
		write_reg(lrcf_pkg::REG_SLOTS, 27'd5);
		write_reg(lrcf_pkg::REG_GAP, 27'd32);
		write_reg(lrcf_pkg::REG_DECAY, 27'd16535435);
		write_reg(lrcf_pkg::REG_INVDECAY, 27'd17022500);
		squeeze = 1'b1;
		random_phase(4, 30);
		squeeze = 1'b0;
		drain();

		write_reg(lrcf_pkg::REG_SLOTS, 27'd3);
		write_reg(lrcf_pkg::REG_GAP, 27'd65535);
		random_phase(4, 15);
		drain();

		write_reg(lrcf_pkg::REG_SLOTS, 27'd16);
		write_reg(lrcf_pkg::REG_DIM, 27'd2);
		write_reg(lrcf_pkg::REG_GAP, 27'd1);
		write_reg(lrcf_pkg::REG_DECAY, 27'd0);
		write_reg(lrcf_pkg::REG_INVDECAY, 27'd0);
		random_phase(2, 12);
		drain();

		write_reg(lrcf_pkg::REG_SLOTS, 27'd31);
		write_reg(lrcf_pkg::REG_DIM, 27'd0);
		write_reg(lrcf_pkg::REG_GAP, {11'd0, 16'($urandom_range(1, 65535))});
		write_reg(lrcf_pkg::REG_DECAY, {1'b0, 26'($urandom_range(0, 33554432))});
		write_reg(lrcf_pkg::REG_INVDECAY, 27'($urandom_range(0, 67108864)));
		random_phase(1, 10);
		drain();

		$display("sent %0d items over %0d register settings", items_sent, settings_used);
		$display("checked %0d product elements", results_seen);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/lrcf_pkg.sv
src/lrcf_if.sv
src/low_rank_cholesky_factor_engine.sv
src/lrcf_checker.sv
verif/lrcf_product_checker.sv
verif/tb.sv
